### rtl/bmb_pkg.sv
`default_nettype none

package bmb_pkg;

   // field and datapath widths
   localparam int COORD_W    = 32;
   localparam int ENTRY_W    = 32;
   localparam int MAG_W      = 32;               // |eye - target| per axis
   localparam int SQ_W       = 2 * MAG_W;        // squares and cross products
   localparam int L2_W       = SQ_W + 1;         // dx^2 + dz^2
   localparam int D2_W       = SQ_W + 2;         // dx^2 + dy^2 + dz^2
   localparam int HALF_W     = 33;               // wide multiplier chunk
   localparam int OPND_W     = 2 * HALF_W;       // wide multiplier operand
   localparam int WIDE_W     = 2 * OPND_W;       // wide multiplier product

   // per-lane normalizer: restoring divide then digit-by-digit square root
   localparam int QUO_W      = 63;               // floor(a^2 * 2^62 / s) <= 2^62
   localparam int DIV_STEPS  = QUO_W;
   localparam int ROOT_W     = 32;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int SREM_W     = ROOT_W + 1;
   localparam int UNIT_W     = ROOT_W - 1;       // rounded magnitude <= 2^30

   localparam int WMUL_LAT   = 3;
   localparam int FRONT_LAT  = 3 + WMUL_LAT;
   localparam int LANE_LAT   = DIV_STEPS + SQRT_STEPS;
   localparam int TOTAL_LAT  = FRONT_LAT + LANE_LAT;

   localparam logic [ENTRY_W-1:0] ONE_Q30 = 32'h4000_0000;

   localparam logic KIND_AXIS = 1'b0;
   localparam logic KIND_FREE = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] eye_x;
      logic signed [COORD_W-1:0] eye_y;
      logic signed [COORD_W-1:0] eye_z;
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic signed [COORD_W-1:0] target_z;
   } req_type;

   typedef struct packed {
      logic                      matrix_kind;
      logic signed [ENTRY_W-1:0] r0c0;
      logic signed [ENTRY_W-1:0] r0c1;
      logic signed [ENTRY_W-1:0] r0c2;
      logic signed [ENTRY_W-1:0] r1c0;
      logic signed [ENTRY_W-1:0] r1c1;
      logic signed [ENTRY_W-1:0] r1c2;
      logic signed [ENTRY_W-1:0] r2c0;
      logic signed [ENTRY_W-1:0] r2c1;
      logic signed [ENTRY_W-1:0] r2c2;
      logic                      is_final;
   } rsp_type;

   typedef struct packed {
      logic dx_pos;
      logic dx_neg;
      logic dy_pos;
      logic dy_neg;
      logic dz_pos;
      logic dz_neg;
   } flags_type;

   typedef struct packed {
      flags_type          flags;
      logic [L2_W-1:0]    l2;
      logic [D2_W-1:0]    d2;
      logic [SQ_W-1:0]    ax2;
      logic [SQ_W-1:0]    ay2;
      logic [SQ_W-1:0]    az2;
   } narrow_type;

   typedef struct packed {
      narrow_type         nar;
      logic [WIDE_W-1:0]  axy2;
      logic [WIDE_W-1:0]  ayz2;
      logic [WIDE_W-1:0]  ld;
   } front_type;

   function automatic logic signed [ENTRY_W-1:0] to_q30(input logic neg,
                                                       input logic [UNIT_W-1:0] mag);
      logic signed [ENTRY_W-1:0] v;
      v = signed'({1'b0, mag});
      return neg ? -v : v;
   endfunction

endpackage

`default_nettype wire

### rtl/bmb_wmul.sv
`default_nettype none

// unsigned wide multiplier, four chunk products then two add stages
module bmb_wmul (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [bmb_pkg::OPND_W-1:0]  a,
   input  wire logic [bmb_pkg::OPND_W-1:0]  b,
   output logic      [bmb_pkg::WIDE_W-1:0]  p
);
   localparam int HW = bmb_pkg::HALF_W;
   localparam int OW = bmb_pkg::OPND_W;
   localparam int WW = bmb_pkg::WIDE_W;

   logic [OW-1:0] pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [OW:0]   mid_ff;
   logic [WW-1:0] outer_ff;
   logic [WW-1:0] p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pp00_ff  <= OW'(a[HW-1:0])  * OW'(b[HW-1:0]);
         pp01_ff  <= OW'(a[HW-1:0])  * OW'(b[OW-1:HW]);
         pp10_ff  <= OW'(a[OW-1:HW]) * OW'(b[HW-1:0]);
         pp11_ff  <= OW'(a[OW-1:HW]) * OW'(b[OW-1:HW]);
         mid_ff   <= (OW+1)'(pp01_ff) + (OW+1)'(pp10_ff);
         outer_ff <= {pp11_ff, pp00_ff};
         p_ff     <= outer_ff + (WW'(mid_ff) << HW);
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

### rtl/bmb_front.sv
`default_nettype none

// direction, squares and lengths for every lane, and the wide products for lanes 2 and 4
module bmb_front (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire bmb_pkg::req_type    req,
   output bmb_pkg::front_type       fr
);
   localparam int MW = bmb_pkg::MAG_W;
   localparam int SW = bmb_pkg::SQ_W;
   localparam int LW = bmb_pkg::L2_W;
   localparam int DW = bmb_pkg::D2_W;
   localparam int OW = bmb_pkg::OPND_W;
   localparam int NL = bmb_pkg::WMUL_LAT;

   logic [MW:0] dx_in, dy_in, dz_in;
   logic [MW-1:0] ax_ff, ay_ff, az_ff;
   bmb_pkg::flags_type flg0_ff, flg1_ff, flg0_in;

   logic [SW-1:0] ax2_ff, ay2_ff, az2_ff, axy_ff, ayz_ff;
   logic [LW-1:0] l2_in;
   bmb_pkg::narrow_type nar_ff;
   logic [SW-1:0] axy2_ff, ayz2_ff;
   bmb_pkg::narrow_type dly_ff [NL];

   // differences at full width, then magnitude and sign
   assign dx_in = {req.eye_x[MW-1], req.eye_x} - {req.target_x[MW-1], req.target_x};
   assign dy_in = {req.eye_y[MW-1], req.eye_y} - {req.target_y[MW-1], req.target_y};
   assign dz_in = {req.eye_z[MW-1], req.eye_z} - {req.target_z[MW-1], req.target_z};

   assign flg0_in.dx_pos = !dx_in[MW] && (dx_in != '0);
   assign flg0_in.dx_neg = dx_in[MW];
   assign flg0_in.dy_pos = !dy_in[MW] && (dy_in != '0);
   assign flg0_in.dy_neg = dy_in[MW];
   assign flg0_in.dz_pos = !dz_in[MW] && (dz_in != '0);
   assign flg0_in.dz_neg = dz_in[MW];

   assign l2_in = LW'(ax2_ff) + LW'(az2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff   <= dx_in[MW] ? MW'(-dx_in) : dx_in[MW-1:0];
         ay_ff   <= dy_in[MW] ? MW'(-dy_in) : dy_in[MW-1:0];
         az_ff   <= dz_in[MW] ? MW'(-dz_in) : dz_in[MW-1:0];
         flg0_ff <= flg0_in;

         ax2_ff  <= SW'(ax_ff) * SW'(ax_ff);
         ay2_ff  <= SW'(ay_ff) * SW'(ay_ff);
         az2_ff  <= SW'(az_ff) * SW'(az_ff);
         axy_ff  <= SW'(ax_ff) * SW'(ay_ff);
         ayz_ff  <= SW'(ay_ff) * SW'(az_ff);
         flg1_ff <= flg0_ff;

         nar_ff.flags <= flg1_ff;
         nar_ff.l2    <= l2_in;
         nar_ff.d2    <= DW'(l2_in) + DW'(ay2_ff);
         nar_ff.ax2   <= ax2_ff;
         nar_ff.ay2   <= ay2_ff;
         nar_ff.az2   <= az2_ff;
         axy2_ff      <= axy_ff;
         ayz2_ff      <= ayz_ff;

         dly_ff[0] <= nar_ff;
         for (int i = 1; i < NL; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   bmb_wmul u_mul_ld (
      .clock (clock),
      .en    (en),
      .a     (OW'(nar_ff.l2)),
      .b     (nar_ff.d2),
      .p     (fr.ld)
   );

   bmb_wmul u_mul_axy (
      .clock (clock),
      .en    (en),
      .a     (OW'(axy2_ff)),
      .b     (OW'(axy2_ff)),
      .p     (fr.axy2)
   );

   bmb_wmul u_mul_ayz (
      .clock (clock),
      .en    (en),
      .a     (OW'(ayz2_ff)),
      .b     (OW'(ayz2_ff)),
      .p     (fr.ayz2)
   );

   assign fr.nar = dly_ff[NL-1];

endmodule

`default_nettype wire

### rtl/bmb_lane.sv
`default_nettype none

// round(2^30 * sqrt(num / den)), num <= den: one quotient bit, then one root bit per stage
module bmb_lane #(
   parameter int SW = bmb_pkg::L2_W
) (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [SW-1:0]               num,
   input  wire logic [SW-1:0]               den,
   output logic      [bmb_pkg::UNIT_W-1:0]  unit
);
   localparam int DS  = bmb_pkg::DIV_STEPS;
   localparam int QW  = bmb_pkg::QUO_W;
   localparam int SS  = bmb_pkg::SQRT_STEPS;
   localparam int RW  = bmb_pkg::ROOT_W;
   localparam int RDW = bmb_pkg::RAD_W;
   localparam int SRW = bmb_pkg::SREM_W;

   logic [SW-1:0]  rem_ff  [DS];
   logic [SW-1:0]  den_ff  [DS];
   logic [QW-1:0]  quo_ff  [DS];
   logic [RDW-1:0] rad_ff  [SS];
   logic [RW-1:0]  root_ff [SS];
   logic [SRW-1:0] srem_ff [SS];
   logic [SW-1:0]  den_in;
   logic [RW-1:0]  sum;

   // zero numerator gives zero; keeps a zero divisor out of the divider
   assign den_in = (num == '0) ? SW'(1) : den;

   for (genvar k = 0; k < DS; k++) begin : g_div
      logic [SW-1:0] rem_prev, den_prev;
      logic [QW-1:0] quo_prev;
      logic [SW:0]   t, diff;
      logic          ge;
      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den_in;
         assign quo_prev = '0;
         assign t        = {1'b0, rem_prev};
      end else begin : g_rest
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign t        = {rem_prev, 1'b0};
      end
      assign ge   = t >= {1'b0, den_prev};
      assign diff = t - {1'b0, den_prev};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[SW-1:0] : t[SW-1:0];
            den_ff[k] <= den_prev;
            quo_ff[k] <= {quo_prev[QW-2:0], ge};
         end
      end
   end

   for (genvar j = 0; j < SS; j++) begin : g_sqrt
      logic [RDW-1:0] rad_prev;
      logic [RW-1:0]  root_prev;
      logic [SRW-1:0] srem_prev;
      logic [SRW+1:0] rs, trial, sdiff;
      logic           ge;
      if (j == 0) begin : g_first
         assign rad_prev  = {1'b0, quo_ff[DS-1]};
         assign root_prev = '0;
         assign srem_prev = '0;
      end else begin : g_rest
         assign rad_prev  = rad_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign srem_prev = srem_ff[j-1];
      end
      assign rs    = {srem_prev, rad_prev[RDW-1 -: 2]};
      assign trial = {1'b0, root_prev, 2'b01};
      assign ge    = rs >= trial;
      assign sdiff = rs - trial;
      always_ff @(posedge clock) begin
         if (en) begin
            srem_ff[j] <= ge ? sdiff[SRW-1:0] : rs[SRW-1:0];
            root_ff[j] <= {root_prev[RW-2:0], ge};
            rad_ff[j]  <= {rad_prev[RDW-3:0], 2'b00};
         end
      end
   end

   // floor(2^31 * q) -> round(2^30 * q)
   assign sum  = root_ff[SS-1] + RW'(1);
   assign unit = sum[RW-1:1];

endmodule

`default_nettype wire

### rtl/billboard_matrix_builder_unit.sv
// billboard matrix builder
// req channel: one word per item, an eye point and a target point in signed
//   Q16.16, taken when req_valid and req_ready are both high
// rsp channel: two words per item, in order: the y-axis-constrained
//   billboard (matrix_kind 0) and then the free billboard (matrix_kind 1,
//   is_final 1); entries are signed Q1.30, exactly rounded
// the first word of an item shows on rsp_valid once the item has passed
//   the whole pipeline, the second in the next cycle when rsp_ready stays high
// the two-word output register pair takes a new item only once the second
//   word of the last one is taken; inside, the 101-stage pipeline can take
//   an item every cycle while not stalled; the pipeline: 6 front stages
//   (difference, squares, lengths, 3-stage wide multiplier) and 8 normalizer
//   lanes of 63 divide and 32 square-root stages, one bit per stage
// reset clears the pipeline and output valid bits, not the data; no clearing pass
// when the receiver stalls the whole pipeline holds once a finished item
//   waits at its end; req_ready drops and nothing is lost or repeated
`default_nettype none

module billboard_matrix_builder_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire bmb_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bmb_pkg::rsp_type       rsp_data
);
   localparam int TL = bmb_pkg::TOTAL_LAT;
   localparam int LL = bmb_pkg::LANE_LAT;
   localparam int UW = bmb_pkg::UNIT_W;
   localparam int LW = bmb_pkg::L2_W;
   localparam int DW = bmb_pkg::D2_W;
   localparam int WW = bmb_pkg::WIDE_W;

   // pipeline control
   logic [TL-1:0] vld_ff;
   logic          en;
   logic          can_load;
   logic          load;

   // data path
   bmb_pkg::front_type fr;
   bmb_pkg::flags_type flg_ff [LL];
   bmb_pkg::flags_type f;
   logic [UW-1:0] m0, m1, m2, m3, m4, m5, m6, m7;
   bmb_pkg::rsp_type mat0_in, mat1_in;

   // output word pair
   bmb_pkg::rsp_type out_ff, nxt_ff;
   logic             out_vld_ff, nxt_vld_ff;

   // a new item may enter the output pair once the second word is gone
   assign can_load = !nxt_vld_ff && (!out_vld_ff || rsp_ready);
   assign en       = can_load || !vld_ff[TL-1];
   assign load     = vld_ff[TL-1] && can_load;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TL-2:0], req_valid};
      end
   end

   bmb_front u_front (
      .clock (clock),
      .en    (en),
      .req   (req_data),
      .fr    (fr)
   );

   // signs ride alongside the lanes
   always_ff @(posedge clock) begin
      if (en) begin
         flg_ff[0] <= fr.nar.flags;
         for (int i = 1; i < LL; i++) begin
            flg_ff[i] <= flg_ff[i-1];
         end
      end
   end

   // x row: dz / L and dx / L
   bmb_lane #(.SW(LW)) u_lane0 (
      .clock (clock), .en (en),
      .num (LW'(fr.nar.az2)), .den (fr.nar.l2), .unit (m0)
   );
   bmb_lane #(.SW(LW)) u_lane1 (
      .clock (clock), .en (en),
      .num (LW'(fr.nar.ax2)), .den (fr.nar.l2), .unit (m1)
   );
   // free billboard middle row: (-dx*dy, L^2, -dy*dz) / (L*|d|)
   bmb_lane #(.SW(WW)) u_lane2 (
      .clock (clock), .en (en),
      .num (fr.axy2), .den (fr.ld), .unit (m2)
   );
   // L^2 / (L*|d|) reduces to L / |d|
   bmb_lane #(.SW(DW)) u_lane3 (
      .clock (clock), .en (en),
      .num (DW'(fr.nar.l2)), .den (fr.nar.d2), .unit (m3)
   );
   bmb_lane #(.SW(WW)) u_lane4 (
      .clock (clock), .en (en),
      .num (fr.ayz2), .den (fr.ld), .unit (m4)
   );
   // normalized view direction
   bmb_lane #(.SW(DW)) u_lane5 (
      .clock (clock), .en (en),
      .num (DW'(fr.nar.ax2)), .den (fr.nar.d2), .unit (m5)
   );
   bmb_lane #(.SW(DW)) u_lane6 (
      .clock (clock), .en (en),
      .num (DW'(fr.nar.ay2)), .den (fr.nar.d2), .unit (m6)
   );
   bmb_lane #(.SW(DW)) u_lane7 (
      .clock (clock), .en (en),
      .num (DW'(fr.nar.az2)), .den (fr.nar.d2), .unit (m7)
   );

   assign f = flg_ff[LL-1];

   // y-axis-constrained billboard: rows X, up, -Z
   always_comb begin
      mat0_in.matrix_kind = bmb_pkg::KIND_AXIS;
      mat0_in.r0c0        = bmb_pkg::to_q30(f.dz_neg, m0);
      mat0_in.r0c1        = '0;
      mat0_in.r0c2        = bmb_pkg::to_q30(f.dx_pos, m1);
      mat0_in.r1c0        = '0;
      mat0_in.r1c1        = signed'(bmb_pkg::ONE_Q30);
      mat0_in.r1c2        = '0;
      mat0_in.r2c0        = bmb_pkg::to_q30(f.dx_pos, m1);
      mat0_in.r2c1        = '0;
      mat0_in.r2c2        = bmb_pkg::to_q30(f.dz_pos, m0);
      mat0_in.is_final    = 1'b0;
   end

   // free billboard: rows X, normalize(d x X), -normalize(d)
   always_comb begin
      mat1_in.matrix_kind = bmb_pkg::KIND_FREE;
      mat1_in.r0c0        = bmb_pkg::to_q30(f.dz_neg, m0);
      mat1_in.r0c1        = '0;
      mat1_in.r0c2        = bmb_pkg::to_q30(f.dx_pos, m1);
      mat1_in.r1c0        = bmb_pkg::to_q30((f.dx_pos && f.dy_pos) ||
                                            (f.dx_neg && f.dy_neg), m2);
      mat1_in.r1c1        = bmb_pkg::to_q30(1'b0, m3);
      mat1_in.r1c2        = bmb_pkg::to_q30((f.dy_pos && f.dz_pos) ||
                                            (f.dy_neg && f.dz_neg), m4);
      mat1_in.r2c0        = bmb_pkg::to_q30(f.dx_pos, m5);
      mat1_in.r2c1        = bmb_pkg::to_q30(f.dy_pos, m6);
      mat1_in.r2c2        = bmb_pkg::to_q30(f.dz_pos, m7);
      mat1_in.is_final    = 1'b1;
   end

   // output register plus one pending word
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         nxt_vld_ff <= 1'b0;
      end else if (load) begin
         out_vld_ff <= 1'b1;
         nxt_vld_ff <= 1'b1;
      end else if (out_vld_ff && rsp_ready) begin
         out_vld_ff <= nxt_vld_ff;
         nxt_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= mat0_in;
         nxt_ff <= mat1_in;
      end else if (out_vld_ff && rsp_ready && nxt_vld_ff) begin
         out_ff <= nxt_ff;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // pending second word never sits behind an empty output register
   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      nxt_vld_ff |-> out_vld_ff)
      else $error("pending word without a word in front");

   // a first word always has its partner queued
   a_first_has_second : assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_ff.is_final) |-> nxt_vld_ff)
      else $error("first word shown without its second word");

   // a fresh item always starts with the constrained billboard
   a_load_kind : assert property (@(posedge clock) disable iff (reset)
      load |=> (out_ff.matrix_kind == bmb_pkg::KIND_AXIS && nxt_vld_ff))
      else $error("item did not start with the constrained billboard");

endmodule

`default_nettype wire
